/* hdl/bps_pkg.sv */
// types, codes and pattern tables for the buzzer prompt sequencer
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

   // request kinds
   localparam logic [1:0] KIND_UPDATE  = 2'd0;
   localparam logic [1:0] KIND_BACK    = 2'd1;
   localparam logic [1:0] KIND_FORWARD = 2'd2;
   localparam logic [1:0] KIND_CONFIRM = 2'd3;

   // pattern codes
   localparam logic [3:0] PAT_NONE    = 4'd0;
   localparam logic [3:0] PAT_ERROR   = 4'd1;
   localparam logic [3:0] PAT_LINK    = 4'd2;
   localparam logic [3:0] PAT_KEY     = 4'd3;
   localparam logic [3:0] PAT_RELEASE = 4'd4;
   localparam logic [3:0] PAT_BACK    = 4'd5;
   localparam logic [3:0] PAT_FORWARD = 4'd6;
   localparam logic [3:0] PAT_CONFIRM = 4'd7;
   localparam logic [3:0] PAT_WRIST   = 4'd8;
   localparam logic [3:0] PAT_DOUBLE  = 4'd9;

   // reported sound kinds
   localparam logic [3:0] SOUND_NONE    = 4'd0;
   localparam logic [3:0] SOUND_ERROR   = 4'd1;
   localparam logic [3:0] SOUND_LINK    = 4'd2;
   localparam logic [3:0] SOUND_KEY     = 4'd3;
   localparam logic [3:0] SOUND_RELEASE = 4'd4;
   localparam logic [3:0] SOUND_BACK    = 4'd5;
   localparam logic [3:0] SOUND_FORWARD = 4'd6;
   localparam logic [3:0] SOUND_CONFIRM = 4'd7;
   localparam logic [3:0] SOUND_WRIST   = 4'd8;

   localparam logic [7:0] RELEASE_BUTTON_MASK = 8'h08;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] now_ms;
      logic        error_active;
      logic        wrist_limit_active;
      logic [7:0]  key_audio_flags;
      logic [7:0]  double_click_flags;
      logic [7:0]  handle_buttons;
      logic [31:0] link_success_count;
   } item_type;

   typedef struct packed {
      logic [10:0] tone_freq_hz;
      logic [7:0]  tone_duty;
      logic [3:0]  sound_kind;
      logic        playing;
   } result_type;

   typedef struct packed {
      logic [3:0]  pat;
      logic [2:0]  step_index;
      logic [31:0] step_deadline;
      logic [31:0] prompt_start;
      logic [31:0] prior_link_count;
      logic        prior_error;
      logic [7:0]  prior_key_flags;
      logic [7:0]  prior_double_flags;
      logic [7:0]  prior_buttons;
      logic [10:0] out_freq;
      logic [7:0]  out_duty;
   } state_type;

   function automatic logic [10:0] step_freq(input logic [4:0] e);
      logic [10:0] f;
      case (e)
         5'd0:    f = 11'd1760;
         5'd1:    f = 11'd0;
         5'd2:    f = 11'd1760;
         5'd3:    f = 11'd0;
         5'd4:    f = 11'd523;
         5'd5:    f = 11'd0;
         5'd6:    f = 11'd659;
         5'd7:    f = 11'd0;
         5'd8:    f = 11'd784;
         5'd9:    f = 11'd988;
         5'd10:   f = 11'd494;
         5'd11:   f = 11'd523;
         5'd12:   f = 11'd1047;
         5'd13:   f = 11'd523;
         5'd14:   f = 11'd0;
         5'd15:   f = 11'd659;
         5'd16:   f = 11'd0;
         5'd17:   f = 11'd784;
         5'd18:   f = 11'd1047;
         5'd19:   f = 11'd784;
         5'd20:   f = 11'd0;
         5'd21:   f = 11'd1047;
         5'd22:   f = 11'd784;
         5'd23:   f = 11'd0;
         5'd24:   f = 11'd1319;
         default: f = 11'd0;
      endcase
      return f;
   endfunction

   function automatic logic [11:0] step_dur(input logic [4:0] e);
      logic [11:0] d;
      case (e)
         5'd0:    d = 12'd70;
         5'd1:    d = 12'd50;
         5'd2:    d = 12'd90;
         5'd3:    d = 12'd1000;
         5'd4:    d = 12'd70;
         5'd5:    d = 12'd25;
         5'd6:    d = 12'd70;
         5'd7:    d = 12'd25;
         5'd8:    d = 12'd95;
         5'd9:    d = 12'd35;
         5'd10:   d = 12'd45;
         5'd11:   d = 12'd26;
         5'd12:   d = 12'd26;
         5'd13:   d = 12'd35;
         5'd14:   d = 12'd12;
         5'd15:   d = 12'd35;
         5'd16:   d = 12'd12;
         5'd17:   d = 12'd45;
         5'd18:   d = 12'd100;
         5'd19:   d = 12'd150;
         5'd20:   d = 12'd280;
         5'd21:   d = 12'd100;
         5'd22:   d = 12'd180;
         5'd23:   d = 12'd3000;
         5'd24:   d = 12'd35;
         default: d = 12'd0;
      endcase
      return d;
   endfunction

   function automatic logic [4:0] pat_first(input logic [3:0] p);
      logic [4:0] r;
      case (p)
         PAT_LINK:    r = 5'd4;
         PAT_KEY:     r = 5'd9;
         PAT_RELEASE: r = 5'd10;
         PAT_BACK:    r = 5'd11;
         PAT_FORWARD: r = 5'd12;
         PAT_CONFIRM: r = 5'd13;
         PAT_WRIST:   r = 5'd18;
         PAT_DOUBLE:  r = 5'd24;
         default:     r = 5'd0;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] pat_count(input logic [3:0] p);
      logic [2:0] r;
      case (p)
         PAT_ERROR:   r = 3'd4;
         PAT_LINK:    r = 3'd5;
         PAT_KEY:     r = 3'd1;
         PAT_RELEASE: r = 3'd1;
         PAT_BACK:    r = 3'd1;
         PAT_FORWARD: r = 3'd1;
         PAT_CONFIRM: r = 3'd5;
         PAT_WRIST:   r = 3'd6;
         PAT_DOUBLE:  r = 3'd1;
         default:     r = 3'd0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] pat_duty(input logic [3:0] p);
      logic [7:0] r;
      case (p)
         PAT_NONE:  r = 8'd0;
         PAT_ERROR: r = 8'd51;
         PAT_WRIST: r = 8'd38;
         default:   r = 8'd64;
      endcase
      return r;
   endfunction

   function automatic logic [10:0] pat_guard(input logic [3:0] p);
      logic [10:0] r;
      case (p)
         PAT_ERROR:   r = 11'd1500;
         PAT_LINK:    r = 11'd450;
         PAT_KEY:     r = 11'd80;
         PAT_RELEASE: r = 11'd90;
         PAT_BACK:    r = 11'd80;
         PAT_FORWARD: r = 11'd80;
         PAT_CONFIRM: r = 11'd180;
         PAT_WRIST:   r = 11'd1400;
         PAT_DOUBLE:  r = 11'd80;
         default:     r = 11'd0;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] pat_kind(input logic [3:0] p);
      logic [3:0] r;
      case (p)
         PAT_ERROR:   r = SOUND_ERROR;
         PAT_LINK:    r = SOUND_LINK;
         PAT_KEY:     r = SOUND_KEY;
         PAT_RELEASE: r = SOUND_RELEASE;
         PAT_BACK:    r = SOUND_BACK;
         PAT_FORWARD: r = SOUND_FORWARD;
         PAT_CONFIRM: r = SOUND_CONFIRM;
         PAT_WRIST:   r = SOUND_WRIST;
         PAT_DOUBLE:  r = SOUND_KEY;
         default:     r = SOUND_NONE;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

/* hdl/bps_req_if.sv */
// request channel interface: valid, ready and the request fields
`timescale 1ns / 1ps
`default_nettype none

interface bps_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] now_ms;
   logic        error_active;
   logic        wrist_limit_active;
   logic [7:0]  key_audio_flags;
   logic [7:0]  double_click_flags;
   logic [7:0]  handle_buttons;
   logic [31:0] link_success_count;

   modport source (
      output valid, kind, now_ms, error_active, wrist_limit_active,
             key_audio_flags, double_click_flags, handle_buttons, link_success_count,
      input  ready
   );

   modport sink (
      input  valid, kind, now_ms, error_active, wrist_limit_active,
             key_audio_flags, double_click_flags, handle_buttons, link_success_count,
      output ready
   );
endinterface

`default_nettype wire

/* hdl/bps_rsp_if.sv */
// response channel interface: valid, ready and the tone fields
`timescale 1ns / 1ps
`default_nettype none

interface bps_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] tone_freq_hz;
   logic [7:0]  tone_duty;
   logic [3:0]  sound_kind;
   logic        playing;

   modport source (
      output valid, tone_freq_hz, tone_duty, sound_kind, playing,
      input  ready
   );

   modport sink (
      input  valid, tone_freq_hz, tone_duty, sound_kind, playing,
      output ready
   );
endinterface

`default_nettype wire

/* hdl/bps_core.sv */
// next-state and result logic for one request of the prompt sequencer
`timescale 1ns / 1ps
`default_nettype none

module bps_core (
   input  bps_pkg::state_type  cur_state,
   input  bps_pkg::item_type   req_item,
   output bps_pkg::state_type  nxt_state,
   output bps_pkg::result_type rsp_item
);
   import bps_pkg::*;

   function automatic state_type prompt_stop(input state_type s);
      state_type r;
      r               = s;
      r.pat           = PAT_NONE;
      r.step_index    = '0;
      r.step_deadline = '0;
      r.prompt_start  = '0;
      r.out_freq      = '0;
      r.out_duty      = '0;
      return r;
   endfunction

   function automatic state_type prompt_begin(input state_type s, input logic [3:0] p,
                                              input logic [31:0] now);
      state_type r;
      r               = prompt_stop(s);
      r.pat           = p;
      r.prompt_start  = now;
      r.step_deadline = now;
      return r;
   endfunction

   state_type   s;
   logic [31:0] since;
   logic [31:0] late;
   logic [4:0]  step_e;
   logic [7:0]  key_rise;
   logic [7:0]  dbl_rise;
   logic [7:0]  btn_rise;
   logic        released;
   logic        err;
   logic        wrist;

   always_comb begin
      s        = cur_state;
      since    = '0;
      late     = '0;
      step_e   = '0;
      err      = req_item.error_active;
      wrist    = req_item.wrist_limit_active;
      key_rise = req_item.key_audio_flags & ~cur_state.prior_key_flags;
      dbl_rise = req_item.double_click_flags & ~cur_state.prior_double_flags;
      btn_rise = req_item.handle_buttons & ~cur_state.prior_buttons;
      released = ((cur_state.prior_buttons & RELEASE_BUTTON_MASK) != 8'd0) &&
                 ((req_item.handle_buttons & RELEASE_BUTTON_MASK) == 8'd0);
      case (req_item.kind)
         KIND_UPDATE: begin
            // event triggers
            if (req_item.link_success_count != s.prior_link_count) begin
               s                  = prompt_begin(s, PAT_LINK, req_item.now_ms);
               s.prior_link_count = req_item.link_success_count;
            end
            if (dbl_rise != 8'd0) begin
               s = prompt_begin(s, PAT_DOUBLE, req_item.now_ms);
            end else if (released) begin
               s = prompt_begin(s, PAT_RELEASE, req_item.now_ms);
            end else if ((key_rise != 8'd0) || (btn_rise != 8'd0)) begin
               s = prompt_begin(s, PAT_KEY, req_item.now_ms);
            end
            s.prior_key_flags    = req_item.key_audio_flags;
            s.prior_double_flags = req_item.double_click_flags;
            s.prior_buttons      = req_item.handle_buttons;

            // condition prompts
            if (!err && (s.pat == PAT_ERROR)) begin
               s = prompt_stop(s);
            end
            if (!wrist && (s.pat == PAT_WRIST)) begin
               s = prompt_stop(s);
            end
            if (err && !s.prior_error) begin
               s = prompt_begin(s, PAT_ERROR, req_item.now_ms);
            end
            s.prior_error = err;

            // guard timeout, else step advance
            if (s.pat != PAT_NONE) begin
               since = req_item.now_ms - s.prompt_start;
               late  = req_item.now_ms - s.step_deadline;
               if (!since[31] && (since >= {21'd0, pat_guard(s.pat)})) begin
                  s = prompt_stop(s);
               end else if (!late[31]) begin
                  if (s.step_index >= pat_count(s.pat)) begin
                     if ((s.pat == PAT_ERROR) && err) begin
                        s.step_index   = '0;
                        s.prompt_start = req_item.now_ms;
                     end else begin
                        s = prompt_stop(s);
                     end
                  end
                  if (s.pat != PAT_NONE) begin
                     step_e          = pat_first(s.pat) + {2'd0, s.step_index};
                     s.step_index    = s.step_index + 3'd1;
                     s.out_freq      = step_freq(step_e);
                     s.out_duty      = (s.out_freq != 11'd0) ? pat_duty(s.pat) : 8'd0;
                     s.step_deadline = req_item.now_ms + {20'd0, step_dur(step_e)};
                  end
               end
            end

            // persistent conditions on an idle block
            if ((s.pat == PAT_NONE) && err) begin
               s = prompt_begin(s, PAT_ERROR, req_item.now_ms);
            end else if ((s.pat == PAT_NONE) && wrist) begin
               s = prompt_begin(s, PAT_WRIST, req_item.now_ms);
            end
         end
         KIND_BACK: begin
            s = prompt_begin(s, PAT_BACK, req_item.now_ms);
         end
         KIND_FORWARD: begin
            s = prompt_begin(s, PAT_FORWARD, req_item.now_ms);
         end
         KIND_CONFIRM: begin
            s = prompt_begin(s, PAT_CONFIRM, req_item.now_ms);
         end
         default: begin
            s = cur_state;
         end
      endcase
   end

   assign nxt_state             = s;
   assign rsp_item.tone_freq_hz = s.out_freq;
   assign rsp_item.tone_duty    = (s.out_freq != 11'd0) ? s.out_duty : 8'd0;
   assign rsp_item.sound_kind   = pat_kind(s.pat);
   assign rsp_item.playing      = (s.pat != PAT_NONE);

endmodule

`default_nettype wire

/* hdl/buzzer_prompt_sequencer_top.sv */
// buzzer prompt sequencer top level: request register, state and response register
//
// requests arrive on req_ch: an update pass (kind 0) carrying the status flags,
// or a tile prompt request (kinds 1 to 3); every request carries now_ms.
// each request yields exactly one response on rsp_ch with the tone frequency,
// duty, the active sound kind and a playing flag.
// a request transfer loads the request register; once the response register is
// free, the pass runs against the prompt state and loads the response register,
// which holds the response valid on rsp_ch until it transfers.
// throughput is one request per cycle while rsp_ch does not stall: the request
// register and the response register each free up in the cycle their contents
// move on. a stalled rsp_ch holds the response; the request register then holds
// one more request and req_ch.ready drops until the response transfer.
// synchronous reset clears the prompt state (silent, no prompt, all prior
// flags and the link count at zero) and empties both registers.
`timescale 1ns / 1ps
`default_nettype none

module buzzer_prompt_sequencer_top (
   input  wire logic  clock,
   input  wire logic  reset,
   bps_req_if.sink    req_ch,
   bps_rsp_if.source  rsp_ch
);
   import bps_pkg::*;

   logic       in_valid_ff;
   logic       in_valid_in;
   item_type   in_item_ff;
   item_type   in_item_in;
   state_type  state_ff;
   state_type  state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_item_ff;
   result_type rsp_item_in;
   logic       req_xfer;
   logic       pass_go;

   assign pass_go  = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_xfer = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !in_valid_ff || pass_go;

   assign in_item_in.kind               = req_ch.kind;
   assign in_item_in.now_ms             = req_ch.now_ms;
   assign in_item_in.error_active       = req_ch.error_active;
   assign in_item_in.wrist_limit_active = req_ch.wrist_limit_active;
   assign in_item_in.key_audio_flags    = req_ch.key_audio_flags;
   assign in_item_in.double_click_flags = req_ch.double_click_flags;
   assign in_item_in.handle_buttons     = req_ch.handle_buttons;
   assign in_item_in.link_success_count = req_ch.link_success_count;

   assign in_valid_in  = req_xfer || (in_valid_ff && !pass_go);
   assign rsp_valid_in = pass_go || (rsp_valid_ff && !rsp_ch.ready);

   bps_core u_core (
      .cur_state (state_ff),
      .req_item  (in_item_ff),
      .nxt_state (state_in),
      .rsp_item  (rsp_item_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (pass_go) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff <= in_item_in;
      end
      if (pass_go) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.tone_freq_hz = rsp_item_ff.tone_freq_hz;
   assign rsp_ch.tone_duty    = rsp_item_ff.tone_duty;
   assign rsp_ch.sound_kind   = rsp_item_ff.sound_kind;
   assign rsp_ch.playing      = rsp_item_ff.playing;

   // a pass always leaves a response behind
   assert property (@(posedge clock) disable iff (reset) pass_go |=> rsp_valid_ff)
      else $error("pass did not produce a response");

   // an idle sequencer is silent and reports no sound
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.pat == PAT_NONE) |-> (state_ff.out_freq == 11'd0) &&
                                    (state_ff.out_duty == 8'd0))
      else $error("tone left on without a prompt");

   // a playing response carries a sound kind, a silent one carries no duty
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_item_ff.playing == (rsp_item_ff.sound_kind != SOUND_NONE)) &&
                       ((rsp_item_ff.tone_freq_hz != 11'd0) || (rsp_item_ff.tone_duty == 8'd0)))
      else $error("inconsistent response fields");

   // a request held in the register is never dropped before its pass
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !pass_go |=> in_valid_ff && $stable(in_item_ff))
      else $error("pending request lost");

endmodule

`default_nettype wire

/* sim/bps_tone_checker.sv */
// tone checker: predicts each response of the buzzer prompt sequencer and compares it
`timescale 1ns / 1ps

module bps_tone_checker (
   input  logic       clock,
   input  logic       reset,
   bps_req_if         req_ch,
   bps_rsp_if         rsp_ch,
   output int         fail_count,
   output int         pending,
   output int         checked,
   output logic [8:0] kinds_heard
);
   import bps_pkg::*;

   typedef struct packed {
      logic [10:0] hz;
      logic [11:0] ms;
   } note_type;

   typedef struct packed {
      logic [4:0]  first;
      logic [2:0]  count;
      logic [7:0]  duty;
      logic [10:0] guard;
   } pattern_type;

   // predicted prompt state
   logic        tone_on;
   logic [3:0]  cur_kind;
   logic        dbl_sel;
   logic [2:0]  step_idx;
   logic [31:0] step_due;
   logic [31:0] prompt_t0;
   logic [31:0] last_link;
   logic        last_err;
   logic [7:0]  last_keys;
   logic [7:0]  last_dbl;
   logic [7:0]  last_btn;
   logic [10:0] freq;
   logic [7:0]  duty;

   result_type  tone_due[$];
   result_type  want;
   item_type    req_item;
   int          errs = 0;
   int          n_checked = 0;
   logic [8:0]  heard = '0;

   function automatic note_type note_rom(input logic [4:0] e);
      note_type n;
      case (e)
         5'd0:    n = {11'd1760, 12'd70};
         5'd1:    n = {11'd0,    12'd50};
         5'd2:    n = {11'd1760, 12'd90};
         5'd3:    n = {11'd0,    12'd1000};
         5'd4:    n = {11'd523,  12'd70};
         5'd5:    n = {11'd0,    12'd25};
         5'd6:    n = {11'd659,  12'd70};
         5'd7:    n = {11'd0,    12'd25};
         5'd8:    n = {11'd784,  12'd95};
         5'd9:    n = {11'd988,  12'd35};
         5'd10:   n = {11'd494,  12'd45};
         5'd11:   n = {11'd523,  12'd26};
         5'd12:   n = {11'd1047, 12'd26};
         5'd13:   n = {11'd523,  12'd35};
         5'd14:   n = {11'd0,    12'd12};
         5'd15:   n = {11'd659,  12'd35};
         5'd16:   n = {11'd0,    12'd12};
         5'd17:   n = {11'd784,  12'd45};
         5'd18:   n = {11'd1047, 12'd100};
         5'd19:   n = {11'd784,  12'd150};
         5'd20:   n = {11'd0,    12'd280};
         5'd21:   n = {11'd1047, 12'd100};
         5'd22:   n = {11'd784,  12'd180};
         5'd23:   n = {11'd0,    12'd3000};
         5'd24:   n = {11'd1319, 12'd35};
         default: n = '0;
      endcase
      return n;
   endfunction

   function automatic pattern_type pattern_rom(input logic [3:0] p);
      pattern_type r;
      case (p)
         PAT_ERROR:   r = {5'd0,  3'd4, 8'd51, 11'd1500};
         PAT_LINK:    r = {5'd4,  3'd5, 8'd64, 11'd450};
         PAT_KEY:     r = {5'd9,  3'd1, 8'd64, 11'd80};
         PAT_RELEASE: r = {5'd10, 3'd1, 8'd64, 11'd90};
         PAT_BACK:    r = {5'd11, 3'd1, 8'd64, 11'd80};
         PAT_FORWARD: r = {5'd12, 3'd1, 8'd64, 11'd80};
         PAT_CONFIRM: r = {5'd13, 3'd5, 8'd64, 11'd180};
         PAT_WRIST:   r = {5'd18, 3'd6, 8'd38, 11'd1400};
         PAT_DOUBLE:  r = {5'd24, 3'd1, 8'd64, 11'd80};
         default:     r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] pattern_sel();
      logic [3:0] p;
      p = (cur_kind > PAT_WRIST) ? PAT_NONE : cur_kind;
      if (p == PAT_KEY && dbl_sel)
         p = PAT_DOUBLE;
      return p;
   endfunction

   function automatic void stop_tone();
      tone_on   = 1'b0;
      cur_kind  = SOUND_NONE;
      dbl_sel   = 1'b0;
      step_idx  = '0;
      step_due  = '0;
      prompt_t0 = '0;
      freq      = '0;
      duty      = '0;
   endfunction

   function automatic void start_tone(input logic [3:0] p, input logic [31:0] t);
      stop_tone();
      tone_on   = 1'b1;
      cur_kind  = (p == PAT_DOUBLE) ? SOUND_KEY : p;
      dbl_sel   = (p == PAT_DOUBLE);
      prompt_t0 = t;
      step_due  = t;
   endfunction

   function automatic void next_step(input logic [31:0] t, input logic err);
      pattern_type pi;
      note_type    n;
      logic [3:0]  p;
      p  = pattern_sel();
      pi = pattern_rom(p);
      // error pattern loops while the error lasts, others end
      if (step_idx >= pi.count) begin
         if (p == PAT_ERROR && err) begin
            step_idx  = '0;
            prompt_t0 = t;
         end else begin
            stop_tone();
            return;
         end
      end
      n        = note_rom(pi.first + {2'b00, step_idx});
      step_idx = step_idx + 3'd1;
      freq     = n.hz;
      duty     = (n.hz != 0) ? pi.duty : 8'd0;
      step_due = t + {20'd0, n.ms};
   endfunction

   function automatic void run_update(input item_type it);
      logic [7:0]  key_up;
      logic [7:0]  dbl_up;
      logic [7:0]  btn_up;
      logic        let_go;
      logic [31:0] since;
      logic [31:0] late;
      pattern_type pi;
      key_up = it.key_audio_flags & ~last_keys;
      dbl_up = it.double_click_flags & ~last_dbl;
      btn_up = it.handle_buttons & ~last_btn;
      let_go = ((last_btn & RELEASE_BUTTON_MASK) != 0) &&
               ((it.handle_buttons & RELEASE_BUTTON_MASK) == 0);
      if (it.link_success_count != last_link) begin
         start_tone(PAT_LINK, it.now_ms);
         last_link = it.link_success_count;
      end
      if (dbl_up != 0)
         start_tone(PAT_DOUBLE, it.now_ms);
      else if (let_go)
         start_tone(PAT_RELEASE, it.now_ms);
      else if (key_up != 0 || btn_up != 0)
         start_tone(PAT_KEY, it.now_ms);
      last_keys = it.key_audio_flags;
      last_dbl  = it.double_click_flags;
      last_btn  = it.handle_buttons;
      if (!it.error_active && tone_on && cur_kind == SOUND_ERROR)
         stop_tone();
      if (!it.wrist_limit_active && tone_on && cur_kind == SOUND_WRIST)
         stop_tone();
      if (it.error_active && !last_err)
         start_tone(PAT_ERROR, it.now_ms);
      last_err = it.error_active;
      if (tone_on) begin
         since = it.now_ms - prompt_t0;
         late  = it.now_ms - step_due;
         pi    = pattern_rom(pattern_sel());
         if (!since[31] && since >= {21'd0, pi.guard})
            stop_tone();
         else if (!late[31])
            next_step(it.now_ms, it.error_active);
      end
      if (!tone_on && it.error_active)
         start_tone(PAT_ERROR, it.now_ms);
      else if (!tone_on && it.wrist_limit_active)
         start_tone(PAT_WRIST, it.now_ms);
   endfunction

   function automatic result_type predict_tone(input item_type it);
      result_type r;
      case (it.kind)
         KIND_UPDATE:  run_update(it);
         KIND_BACK:    start_tone(PAT_BACK, it.now_ms);
         KIND_FORWARD: start_tone(PAT_FORWARD, it.now_ms);
         default:      start_tone(PAT_CONFIRM, it.now_ms);
      endcase
      r.tone_freq_hz = freq;
      r.tone_duty    = (freq != 0) ? duty : 8'd0;
      r.sound_kind   = tone_on ? cur_kind : SOUND_NONE;
      r.playing      = tone_on;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         stop_tone();
         last_link = '0;
         last_err  = 1'b0;
         last_keys = '0;
         last_dbl  = '0;
         last_btn  = '0;
         tone_due.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (tone_due.size() == 0) begin
               $error("response transfer with nothing expected: freq %0d kind %0d",
                      rsp_ch.tone_freq_hz, rsp_ch.sound_kind);
               errs++;
            end else begin
               want = tone_due.pop_front();
               n_checked++;
               heard[want.sound_kind] = 1'b1;
               if (rsp_ch.tone_freq_hz !== want.tone_freq_hz) begin
                  $error("tone_freq_hz: expected %0d, actual %0d",
                         want.tone_freq_hz, rsp_ch.tone_freq_hz);
                  errs++;
               end
               if (rsp_ch.tone_duty !== want.tone_duty) begin
                  $error("tone_duty: expected %0d, actual %0d",
                         want.tone_duty, rsp_ch.tone_duty);
                  errs++;
               end
               if (rsp_ch.sound_kind !== want.sound_kind) begin
                  $error("sound_kind: expected %0d, actual %0d",
                         want.sound_kind, rsp_ch.sound_kind);
                  errs++;
               end
               if (rsp_ch.playing !== want.playing) begin
                  $error("playing: expected %0d, actual %0d",
                         want.playing, rsp_ch.playing);
                  errs++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            req_item.kind               = req_ch.kind;
            req_item.now_ms             = req_ch.now_ms;
            req_item.error_active       = req_ch.error_active;
            req_item.wrist_limit_active = req_ch.wrist_limit_active;
            req_item.key_audio_flags    = req_ch.key_audio_flags;
            req_item.double_click_flags = req_ch.double_click_flags;
            req_item.handle_buttons     = req_ch.handle_buttons;
            req_item.link_success_count = req_ch.link_success_count;
            tone_due.push_back(predict_tone(req_item));
         end
      end
      fail_count  <= errs;
      pending     <= tone_due.size();
      checked     <= n_checked;
      kinds_heard <= heard;
   end

endmodule

/* sim/tb_buzzer_prompt_sequencer_top.sv */
// testbench top: clock, reset, request stimulus, response stalls and the verdict
`timescale 1ns / 1ps

module tb_buzzer_prompt_sequencer_top;
   import bps_pkg::*;

   localparam int RANDOM_ITEMS = 800;
   localparam int HOLD_CYCLES  = 80;
   localparam int WATCH_LIMIT  = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bps_req_if req_ch();
   bps_rsp_if rsp_ch();

   int         fail_count;
   int         pending;
   int         checked;
   logic [8:0] kinds_heard;

   // stimulus side view of the world
   logic [31:0] cur_ms   = '0;
   logic [31:0] link_cnt = '0;
   logic        err_lvl  = 1'b0;
   logic        wrist_lvl = 1'b0;
   logic [7:0]  key_lvl  = '0;
   logic [7:0]  dbl_lvl  = '0;
   logic [7:0]  btn_lvl  = '0;

   logic calm     = 1'b0;
   logic hold_rsp = 1'b0;
   int   sent     = 0;
   int   quiet    = 0;

   buzzer_prompt_sequencer_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   bps_tone_checker tone_chk (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .fail_count  (fail_count),
      .pending     (pending),
      .checked     (checked),
      .kinds_heard (kinds_heard)
   );

   always #10 clock = ~clock;

   task automatic send(input logic [1:0] k);
      logic is_pass;
      is_pass = (k == KIND_UPDATE);
      req_ch.valid              <= 1'b1;
      req_ch.kind               <= k;
      req_ch.now_ms             <= cur_ms;
      // tile requests carry junk in the status fields
      req_ch.error_active       <= is_pass ? err_lvl : 1'($urandom);
      req_ch.wrist_limit_active <= is_pass ? wrist_lvl : 1'($urandom);
      req_ch.key_audio_flags    <= is_pass ? key_lvl : 8'($urandom);
      req_ch.double_click_flags <= is_pass ? dbl_lvl : 8'($urandom);
      req_ch.handle_buttons     <= is_pass ? btn_lvl : 8'($urandom);
      req_ch.link_success_count <= is_pass ? link_cnt : 32'($urandom);
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent++;
      if (!calm && $urandom_range(0, 99) < 11) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drive_update(input logic [31:0] t, input logic e, input logic w,
                               input logic [7:0] keys, input logic [7:0] dbl,
                               input logic [7:0] btn, input logic [31:0] link);
      cur_ms    = t;
      err_lvl   = e;
      wrist_lvl = w;
      key_lvl   = keys;
      dbl_lvl   = dbl;
      btn_lvl   = btn;
      link_cnt  = link;
      send(KIND_UPDATE);
   endtask

   task automatic drive_tile(input logic [1:0] k, input logic [31:0] t);
      cur_ms = t;
      send(k);
   endtask

   task automatic drift_levels();
      if ($urandom_range(0, 99) < 4)
         err_lvl = ~err_lvl;
      if ($urandom_range(0, 99) < 4)
         wrist_lvl = ~wrist_lvl;
      if ($urandom_range(0, 99) < 15)
         key_lvl[$urandom_range(0, 7)] ^= 1'b1;
      if ($urandom_range(0, 99) < 8)
         dbl_lvl[$urandom_range(0, 7)] ^= 1'b1;
      if ($urandom_range(0, 99) < 15) begin
         if ($urandom_range(0, 1))
            btn_lvl[3] ^= 1'b1;
         else
            btn_lvl[$urandom_range(0, 7)] ^= 1'b1;
      end
      if ($urandom_range(0, 99) < 4)
         link_cnt = link_cnt + 32'd1;
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (pending != 0);
   endtask

   // response side: random stalls plus one long hold-off
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 11);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet = 0;
      else
         quiet++;
      if (quiet >= WATCH_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int r;
      req_ch.valid              = 1'b0;
      req_ch.kind               = KIND_UPDATE;
      req_ch.now_ms             = '0;
      req_ch.error_active       = 1'b0;
      req_ch.wrist_limit_active = 1'b0;
      req_ch.key_audio_flags    = '0;
      req_ch.double_click_flags = '0;
      req_ch.handle_buttons     = '0;
      req_ch.link_success_count = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: idle, link, tiles, presses, release, error loop, wrist, wrap
      drive_update(32'd0,    0, 0, 8'h00, 8'h00, 8'h00, 32'h0);
      drive_update(32'd5,    0, 0, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF);
      drive_update(32'd80,   0, 0, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF);
      drive_tile(KIND_BACK, 32'd90);
      drive_update(32'd91,   0, 0, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF);
      drive_update(32'd171,  0, 0, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF);
      drive_update(32'd175,  0, 0, 8'h80, 8'h00, 8'h01, 32'hFFFF_FFFF);
      drive_update(32'd180,  0, 0, 8'h81, 8'h01, 8'h09, 32'hFFFF_FFFF);
      drive_update(32'd185,  0, 0, 8'h81, 8'h01, 8'h01, 32'hFFFF_FFFF);
      drive_update(32'd190,  0, 0, 8'hFF, 8'hFF, 8'hFF, 32'h0);
      drive_tile(KIND_FORWARD, 32'd200);
      drive_update(32'd201,  0, 0, 8'hFF, 8'hFF, 8'hFF, 32'h0);
      drive_tile(KIND_CONFIRM, 32'd210);
      drive_update(32'd215,  0, 0, 8'hFF, 8'hFF, 8'hFF, 32'h0);
      drive_update(32'd300,  1, 0, 8'h00, 8'h00, 8'h00, 32'h0);
      drive_update(32'd371,  1, 0, 8'h00, 8'h00, 8'h00, 32'h0);
      drive_update(32'd430,  1, 0, 8'h00, 8'h00, 8'h00, 32'h0);
      drive_update(32'd530,  1, 0, 8'h00, 8'h00, 8'h00, 32'h0);
      drive_update(32'd1540, 1, 0, 8'h00, 8'h00, 8'h00, 32'h0);
      drive_update(32'd3100, 1, 1, 8'h00, 8'h00, 8'h00, 32'h0);
      drive_update(32'd3110, 0, 1, 8'h00, 8'h00, 8'h00, 32'h0);
      drive_update(32'd3120, 0, 1, 8'h00, 8'h00, 8'h00, 32'h0);
      drive_update(32'hFFFF_FFF0, 0, 1, 8'h00, 8'h00, 8'h00, 32'h0);
      drive_update(32'h0000_0010, 0, 0, 8'h00, 8'h00, 8'h00, 32'h0);
      drive_update(32'h7FFF_FFFF, 0, 0, 8'h00, 8'h00, 8'h00, 32'h5A5A_A5A5);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         calm = (i >= 250 && i < 400);
         if (i == 500)
            hold_rsp = 1'b1;
         if (i == 650) begin
            req_ch.valid <= 1'b0;
            wait_drained();
         end
         r = $urandom_range(0, 99);
         if (r < 65) begin
            cur_ms = cur_ms + $urandom_range(0, 50);
            drift_levels();
            send(KIND_UPDATE);
         end else if (r < 75) begin
            cur_ms = cur_ms + $urandom_range(0, 20);
            send(2'($urandom_range(KIND_BACK, KIND_CONFIRM)));
         end else if (r < 85) begin
            cur_ms = cur_ms + $urandom_range(60, 3200);
            drift_levels();
            send(KIND_UPDATE);
         end else if (r < 90) begin
            // time steps backward
            cur_ms = cur_ms - $urandom_range(1, 400);
            send(KIND_UPDATE);
         end else if (r < 95) begin
            cur_ms    = $urandom;
            link_cnt  = $urandom;
            key_lvl   = 8'($urandom);
            dbl_lvl   = 8'($urandom);
            btn_lvl   = 8'($urandom);
            err_lvl   = 1'($urandom);
            wrist_lvl = 1'($urandom);
            send(KIND_UPDATE);
         end else begin
            cur_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
            drift_levels();
            send(KIND_UPDATE);
         end
      end

      req_ch.valid <= 1'b0;
      wait_drained();
      repeat (6) @(posedge clock);
      $display("covered %0d requests and %0d checked responses,", sent, checked);
      $display("including a full response stall; sound kinds heard 8..0: %b", kinds_heard);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

/* sim.f */
hdl/bps_pkg.sv
hdl/bps_req_if.sv
hdl/bps_rsp_if.sv
hdl/bps_core.sv
hdl/buzzer_prompt_sequencer_top.sv
sim/bps_tone_checker.sv
sim/tb_buzzer_prompt_sequencer_top.sv
